[src/torq_pkg.sv]
// Package for the timestamp ordered request queue.
// Holds operation and status codes, the slot entry type and the cell control bundle.
// No dependencies.
`default_nettype none

package torq_pkg;

	localparam int DEF_MAX_ENTRIES = 16;

	localparam int TS_W   = 32;
	localparam int SRC_W  = 8;
	localparam int PAY_W  = 16;
	localparam int POS_W  = 4;
	localparam int OCC_W  = 5;
	localparam int OP_W   = 2;
	localparam int STAT_W = 2;

	localparam int S_TDATA_W = 64;
	localparam int S_TUSER_W = 8;
	localparam int M_TDATA_W = 72;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_FIND   = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_MISSING = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef struct packed {
		logic [TS_W-1:0]  ts;
		logic [SRC_W-1:0] src;
		logic [PAY_W-1:0] payload;
	} entry_t;

	typedef struct packed {
		logic   ins;
		logic   rem;
		entry_t ins_entry;
	} cell_ctl_t;

	typedef struct packed {
		op_t              operation;
		entry_t           item;
		logic [POS_W-1:0] position;
	} request_t;

	typedef struct packed {
		status_t          status;
		logic [POS_W-1:0] found_position;
		entry_t           entry;
		logic [OCC_W-1:0] occupancy;
	} result_t;

endpackage

`default_nettype wire

[src/torq_cell.sv]
// One slot of the sorted queue: holds an entry, compares it to the request key
// and shifts from its left or right neighbor on insert or remove. Uses torq_pkg.
`default_nettype none

module torq_cell (
	input  wire logic               clk,
	input  wire torq_pkg::cell_ctl_t ctl,
	input  wire logic               occupied,
	input  wire logic               left_lt,
	input  wire torq_pkg::entry_t   left_entry,
	input  wire torq_pkg::entry_t   right_entry,
	input  wire logic               hit_upto,
	output torq_pkg::entry_t        entry,
	output logic                    lt,
	output logic                    match
);
	import torq_pkg::*;

	entry_t entry_q;

	// key order: timestamp, then source id
	assign lt    = occupied && ({entry_q.ts, entry_q.src} <
	                            {ctl.ins_entry.ts, ctl.ins_entry.src});
	assign match = occupied && (entry_q.src == ctl.ins_entry.src);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.ins && !lt) begin
			entry_q <= left_lt ? ctl.ins_entry : left_entry;
		end else if (ctl.rem && hit_upto) begin
			entry_q <= right_entry;
		end
	end

endmodule

`default_nettype wire

[src/timestamp_ordered_request_queue.sv]
// Top level of the timestamp ordered request queue.
// Builds a row of torq_cell slots with count, request and result registers. Uses torq_pkg.
//
// Usage:
//   Slave channel s_*: one beat is one request. s_tuser[1:0] holds the operation
//   (insert, remove by source, find by source, read at position); s_tdata holds
//   ts, src_id, payload and position. Master channel m_*: one result beat per
//   request with status, found_position, the entry read and the occupancy.
//   Every slot compares itself with the request key at once; on insert or remove
//   each slot from the change point on loads a neighbor or the new entry in the same edge.
//   The taken request waits in the request register and its result is registered
//   in the output register when it executes. The request register holds s_tready
//   low from the time a request is taken until it executes.
//   A finished result waits in the output register while the next request is
//   taken; that request executes once the receiver takes the pending result.
//   Reset empties the queue and drops any pending request or result; slot
//   contents are not cleared.
`default_nettype none

module timestamp_ordered_request_queue #(
	parameter int MAX_ENTRIES = torq_pkg::DEF_MAX_ENTRIES
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// ts[31:0], src_id[39:32], payload[55:40], position[59:56], zero fill
	input  wire logic [torq_pkg::S_TDATA_W-1:0] s_tdata,
	// operation[1:0], zero fill
	input  wire logic [torq_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// status[1:0], found_position[5:2], entry_ts[37:6], entry_src[45:38],
	// entry_payload[61:46], occupancy[66:62], zero fill
	output logic [torq_pkg::M_TDATA_W-1:0]      m_tdata
);
	import torq_pkg::*;

	localparam int CntW = $clog2(MAX_ENTRIES + 1);
	localparam int IdxW = $clog2(MAX_ENTRIES);
	localparam int CmpW = (CntW > POS_W) ? CntW : POS_W;

	request_t         req_s1;
	logic             busy_q;
	logic [CntW-1:0]  count_q;
	logic [CntW-1:0]  count_next;
	result_t          res_q;
	logic             res_valid_q;
	logic             exec;

	entry_t           cell_entry [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] occupied;
	logic [MAX_ENTRIES-1:0] lt;
	logic [MAX_ENTRIES-1:0] match;
	logic [MAX_ENTRIES-1:0] hit_upto;
	logic [MAX_ENTRIES-1:0] first;
	logic [IdxW-1:0]  first_idx;
	logic [IdxW-1:0]  rd_idx;
	logic             full;
	logic             empty;
	logic             found;
	logic             rd_in_range;
	cell_ctl_t        ctl;
	result_t          res_d;

	assign s_tready = !busy_q;
	assign exec     = busy_q && (!res_valid_q || m_tready);

	assign full  = (count_q == CntW'(MAX_ENTRIES));
	assign empty = (count_q == '0);
	assign found = hit_upto[MAX_ENTRIES-1];

	assign ctl.ins       = exec && (req_s1.operation == OP_INSERT) && !full;
	assign ctl.rem       = exec && (req_s1.operation == OP_REMOVE) && found;
	assign ctl.ins_entry = req_s1.item;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		assign occupied[i] = (CntW'(i) < count_q);
		assign hit_upto[i] = |match[i:0];
		if (i == 0) begin : g_head
			assign first[i] = match[i];
			torq_cell u_cell (
				.clk         (clk),
				.ctl         (ctl),
				.occupied    (occupied[i]),
				.left_lt     (1'b1),
				.left_entry  (req_s1.item),
				.right_entry (cell_entry[(i + 1) % MAX_ENTRIES]),
				.hit_upto    (hit_upto[i]),
				.entry       (cell_entry[i]),
				.lt          (lt[i]),
				.match       (match[i])
			);
		end else begin : g_body
			assign first[i] = match[i] && !hit_upto[i-1];
			torq_cell u_cell (
				.clk         (clk),
				.ctl         (ctl),
				.occupied    (occupied[i]),
				.left_lt     (lt[i-1]),
				.left_entry  (cell_entry[i-1]),
				.right_entry ((i == MAX_ENTRIES - 1) ? cell_entry[i]
				                                    : cell_entry[(i + 1) % MAX_ENTRIES]),
				.hit_upto    (hit_upto[i]),
				.entry       (cell_entry[i]),
				.lt          (lt[i]),
				.match       (match[i])
			);
		end
	end

	always_comb begin
		first_idx = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (first[i]) begin
				first_idx = first_idx | IdxW'(i);
			end
		end
	end

	assign rd_idx      = IdxW'(req_s1.position);
	assign rd_in_range = (CmpW'(req_s1.position) < CmpW'(count_q));

	always_comb begin
		count_next = count_q;
		if (ctl.ins) begin
			count_next = count_q + CntW'(1);
		end else if (ctl.rem) begin
			count_next = count_q - CntW'(1);
		end
	end

	always_comb begin
		res_d                = '0;
		res_d.status         = ST_OK;
		unique case (req_s1.operation)
			OP_INSERT: begin
				if (full) res_d.status = ST_FULL;
			end
			OP_REMOVE: begin
				if (empty)       res_d.status = ST_EMPTY;
				else if (!found) res_d.status = ST_MISSING;
			end
			OP_FIND: begin
				if (empty)       res_d.status = ST_EMPTY;
				else if (!found) res_d.status = ST_MISSING;
				else             res_d.found_position = POS_W'(first_idx);
			end
			OP_READ: begin
				if (empty)             res_d.status = ST_EMPTY;
				else if (!rd_in_range) res_d.status = ST_MISSING;
				else                   res_d.entry  = cell_entry[rd_idx];
			end
			default: res_d.status = ST_OK;
		endcase
		res_d.occupancy = OCC_W'(count_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				busy_q <= 1'b1;
			end else if (exec) begin
				busy_q <= 1'b0;
			end
			if (exec) begin
				count_q     <= count_next;
				res_valid_q <= 1'b1;
			end else if (m_tready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1.operation    <= op_t'(s_tuser[OP_W-1:0]);
			req_s1.item.ts      <= s_tdata[31:0];
			req_s1.item.src     <= s_tdata[39:32];
			req_s1.item.payload <= s_tdata[55:40];
			req_s1.position     <= s_tdata[59:56];
		end
		if (exec) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {5'd0, res_q.occupancy, res_q.entry.payload, res_q.entry.src,
	                   res_q.entry.ts, res_q.found_position, res_q.status};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(MAX_ENTRIES))
		else $error("entry count above capacity");

	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		exec |=> res_valid_q)
		else $error("executed request left no result");

	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!exec |=> $stable(count_q))
		else $error("entry count moved without a request");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.status == ST_FULL) |-> full)
		else $error("full status while queue has room");

endmodule

`default_nettype wire
